// File: design/gen_pkg.sv
// Shared constants, event code tables and control types of the gamepad event normaliser.
`timescale 1ns / 1ps
`default_nettype none
package gen_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int RAW_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int NUM_BUTTONS    = 16;
  localparam int NUM_AXES       = 4;
  localparam int PRESENT_W      = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_PRESENT = 3'd4;

  // Event classes
  localparam logic [4:0] EV_SYNC = 5'd0;
  localparam logic [4:0] EV_KEY  = 5'd1;
  localparam logic [4:0] EV_ABS  = 5'd3;

  // Sync and absolute axis codes
  localparam logic [9:0] SYN_END    = 10'd0;
  localparam logic [9:0] ABS_X      = 10'd0;
  localparam logic [9:0] ABS_Y      = 10'd1;
  localparam logic [9:0] ABS_Z      = 10'd2;
  localparam logic [9:0] ABS_RZ     = 10'd5;
  localparam logic [9:0] ABS_GAS    = 10'd9;
  localparam logic [9:0] ABS_BRK    = 10'd10;
  localparam logic [9:0] ABS_HAT_X  = 10'd16;
  localparam logic [9:0] ABS_HAT_Y  = 10'd17;

  // Bits of the axis presence register
  localparam int PRES_X     = 0;
  localparam int PRES_Y     = 1;
  localparam int PRES_Z     = 2;
  localparam int PRES_RZ    = 3;
  localparam int PRES_GAS   = 4;
  localparam int PRES_BRAKE = 5;

  // Standard button numbers
  localparam logic [3:0] BTN_LT   = 4'd6;
  localparam logic [3:0] BTN_RT   = 4'd7;
  localparam logic [3:0] BTN_UP   = 4'd12;
  localparam logic [3:0] BTN_LEFT = 4'd14;

  // Stick slots
  localparam logic [1:0] AX_LX = 2'd0;
  localparam logic [1:0] AX_LY = 2'd1;
  localparam logic [1:0] AX_RX = 2'd2;
  localparam logic [1:0] AX_RY = 2'd3;

  // Trigger slots handed to the scaler
  localparam logic [1:0] TRG_LEFT  = 2'd0;
  localparam logic [1:0] TRG_RIGHT = 2'd1;

  localparam int KEY_ENTRIES = 17;

  localparam logic [9:0] KEY_CODES [KEY_ENTRIES] = '{
    10'd304, 10'd305, 10'd307, 10'd308, 10'd310, 10'd311, 10'd312, 10'd313,
    10'd314, 10'd315, 10'd317, 10'd318, 10'd17, 10'd16, 10'd10, 10'd9, 10'd158
  };

  localparam logic [3:0] KEY_IDS [KEY_ENTRIES] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd14, 4'd6, 4'd7, 4'd8
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] id;
  } key_hit_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] stick_min;
    logic signed [RAW_W-1:0] stick_max;
    logic signed [RAW_W-1:0] trigger_min;
    logic signed [RAW_W-1:0] trigger_max;
  } range_cfg_t;

  typedef struct packed {
    logic       go;
    logic       trig;
    logic [1:0] idx;
  } scl_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic       trig;
    logic [1:0] idx;
  } scl_stat_t;

  // Key code to button number; codes are unique so the order of the scan is immaterial.
  function automatic key_hit_t key_lookup(input logic [9:0] code);
    key_hit_t r;
    r.hit = 1'b0;
    r.id  = 4'd0;
    for (int i = 0; i < KEY_ENTRIES; i++) begin
      if (KEY_CODES[i] == code) begin
        r.hit = 1'b1;
        r.id  = KEY_IDS[i];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/gamepad_event_normalizer.sv
// Top level: event decode, button and axis state, report register and configuration.
// Key, hat, ignored and sync events are handled without the scaler; a sync report
// appears on the output register in the cycle after the sync event is accepted. A
// present stick or trigger event keeps the input stalled while the scaler is busy,
// which includes the restoring divider that yields one quotient bit a cycle; an empty
// range skips the divider. Synchronous active-low reset restores the range defaults
// and clears all levels, change flags and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module gamepad_event_normalizer
  import gen_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [4:0]                    in_event_type,
  input  wire logic [9:0]                    in_event_code,
  input  wire logic signed [RAW_W-1:0]       in_event_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_buttons_changed,
  output logic                               out_axes_changed,
  output logic [NUM_BUTTONS-1:0]             out_button_mask,
  output logic [VALUE_BITS-2:0]              out_left_trigger,
  output logic [VALUE_BITS-2:0]              out_right_trigger,
  output logic signed [VALUE_BITS-1:0]       out_left_x,
  output logic signed [VALUE_BITS-1:0]       out_left_y,
  output logic signed [VALUE_BITS-1:0]       out_right_x,
  output logic signed [VALUE_BITS-1:0]       out_right_y,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int QW = VALUE_BITS - 1;
  localparam logic [QW-1:0] LEVEL_FULL = '1;

  range_cfg_t               rng_r, rng_nxt;
  logic [PRESENT_W-1:0]     present_r, present_nxt;
  logic [NUM_BUTTONS-1:0]   btn_on_r, btn_on_nxt;
  logic [QW-1:0]            lt_r, lt_nxt;
  logic [QW-1:0]            rt_r, rt_nxt;
  logic signed [VALUE_BITS-1:0] axis_r [NUM_AXES];
  logic signed [VALUE_BITS-1:0] axis_nxt [NUM_AXES];
  logic                     bdirty_r, bdirty_nxt;
  logic                     adirty_r, adirty_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     o_bch_r, o_ach_r;
  logic [NUM_BUTTONS-1:0]   o_mask_r;
  logic [QW-1:0]            o_lt_r, o_rt_r;
  logic signed [VALUE_BITS-1:0] o_axis_r [NUM_AXES];
  logic                     load_out;

  logic                     accept;
  key_hit_t                 key;
  logic                     key_on;
  logic [3:0]               hat_base;
  logic [3:0]               hat_next;
  scl_cmd_t                 cmd;
  scl_stat_t                stat;
  logic signed [VALUE_BITS-1:0] scl_result;
  logic [QW-1:0]            trg_level;

  gen_scaler #(.VALUE_BITS(VALUE_BITS)) u_scaler (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .value_in (in_event_value),
    .rng      (rng_r),
    .stat     (stat),
    .result   (scl_result)
  );

  assign in_stall  = stat.busy || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign key       = key_lookup(in_event_code);
  assign key_on    = (in_event_value != '0);
  assign hat_base  = (in_event_code == ABS_HAT_Y) ? BTN_UP : BTN_LEFT;
  assign hat_next  = hat_base + 4'd1;
  assign trg_level = scl_result[QW-1:0];

  always_comb begin
    rng_nxt     = rng_r;
    present_nxt = present_r;
    btn_on_nxt  = btn_on_r;
    lt_nxt      = lt_r;
    rt_nxt      = rt_r;
    axis_nxt    = axis_r;
    bdirty_nxt  = bdirty_r;
    adirty_nxt  = adirty_r;
    cmd         = '0;
    load_out    = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STICK_MIN:    rng_nxt.stick_min   = cfg_data;
        CFG_STICK_MAX:    rng_nxt.stick_max   = cfg_data;
        CFG_TRIGGER_MIN:  rng_nxt.trigger_min = cfg_data;
        CFG_TRIGGER_MAX:  rng_nxt.trigger_max = cfg_data;
        CFG_AXIS_PRESENT: present_nxt         = cfg_data[PRESENT_W-1:0];
        default: begin
        end
      endcase
    end

    if (accept) begin
      priority if (in_event_type == EV_SYNC) begin
        if (in_event_code == SYN_END) begin
          load_out   = 1'b1;
          bdirty_nxt = 1'b0;
          adirty_nxt = 1'b0;
        end
      end else if (in_event_type == EV_KEY) begin
        if (key.hit) begin
          btn_on_nxt[key.id] = key_on;
          if (key.id == BTN_LT) begin
            lt_nxt = key_on ? LEVEL_FULL : '0;
          end
          if (key.id == BTN_RT) begin
            rt_nxt = key_on ? LEVEL_FULL : '0;
          end
          bdirty_nxt = 1'b1;
        end
      end else if (in_event_type == EV_ABS) begin
        priority if (in_event_code == ABS_GAS) begin
          cmd.go   = present_r[PRES_GAS];
          cmd.trig = 1'b1;
          cmd.idx  = TRG_RIGHT;
        end else if (in_event_code == ABS_BRK) begin
          cmd.go   = present_r[PRES_BRAKE];
          cmd.trig = 1'b1;
          cmd.idx  = TRG_LEFT;
        end else if ((in_event_code == ABS_HAT_X) || (in_event_code == ABS_HAT_Y)) begin
          // Negative selects up or left, positive down or right.
          btn_on_nxt[hat_base] = key_on && in_event_value[RAW_W-1];
          btn_on_nxt[hat_next] = key_on && !in_event_value[RAW_W-1];
          bdirty_nxt           = 1'b1;
        end else if (in_event_code == ABS_X) begin
          cmd.go  = present_r[PRES_X];
          cmd.idx = AX_LX;
        end else if (in_event_code == ABS_Y) begin
          cmd.go  = present_r[PRES_Y];
          cmd.idx = AX_LY;
        end else if (in_event_code == ABS_Z) begin
          cmd.go  = present_r[PRES_Z];
          cmd.idx = AX_RX;
        end else if (in_event_code == ABS_RZ) begin
          cmd.go  = present_r[PRES_RZ];
          cmd.idx = AX_RY;
        end else begin
          // Other axis codes leave the state alone.
        end
      end else begin
        // Other event classes are ignored.
      end
    end

    if (stat.done) begin
      if (stat.trig) begin
        if (stat.idx == TRG_LEFT) begin
          lt_nxt             = trg_level;
          btn_on_nxt[BTN_LT] = (trg_level != '0);
        end else begin
          rt_nxt             = trg_level;
          btn_on_nxt[BTN_RT] = (trg_level != '0);
        end
        bdirty_nxt = 1'b1;
      end else begin
        axis_nxt[stat.idx] = scl_result;
        adirty_nxt         = 1'b1;
      end
    end
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r.stick_min   <= -32'sd32768;
      rng_r.stick_max   <= 32'sd32767;
      rng_r.trigger_min <= 32'sd0;
      rng_r.trigger_max <= 32'sd255;
      present_r         <= '0;
      btn_on_r          <= '0;
      lt_r              <= '0;
      rt_r              <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_r[i] <= '0;
      end
      bdirty_r    <= 1'b0;
      adirty_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rng_r       <= rng_nxt;
      present_r   <= present_nxt;
      btn_on_r    <= btn_on_nxt;
      lt_r        <= lt_nxt;
      rt_r        <= rt_nxt;
      axis_r      <= axis_nxt;
      bdirty_r    <= bdirty_nxt;
      adirty_r    <= adirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The report beat is a snapshot taken as the sync event is accepted.
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_bch_r  <= bdirty_r;
      o_ach_r  <= adirty_r;
      o_mask_r <= btn_on_r;
      o_lt_r   <= lt_r;
      o_rt_r   <= rt_r;
      o_axis_r <= axis_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_buttons_changed = o_bch_r;
  assign out_axes_changed    = o_ach_r;
  assign out_button_mask     = o_mask_r;
  assign out_left_trigger    = o_lt_r;
  assign out_right_trigger   = o_rt_r;
  assign out_left_x          = o_axis_r[AX_LX];
  assign out_left_y          = o_axis_r[AX_LY];
  assign out_right_x         = o_axis_r[AX_RX];
  assign out_right_y         = o_axis_r[AX_RY];

endmodule
`default_nettype wire

// File: design/gen_alu.sv
// Shared signed adder and subtractor used by every step of the scaler.
`timescale 1ns / 1ps
`default_nettype none
module gen_alu #(
  parameter int W = 52
) (
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  input  wire logic                sub,
  output logic signed [W-1:0]      y,
  output logic                     y_neg,
  output logic                     y_zero
);

  assign y      = sub ? (a - b) : (a + b);
  assign y_neg  = y[W-1];
  assign y_zero = (y == '0);

endmodule
`default_nettype wire

// File: design/gen_scaler.sv
// Sequencer that normalises one stick or trigger value through the shared adder.
`timescale 1ns / 1ps
`default_nettype none
module gen_scaler
  import gen_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire scl_cmd_t                     cmd,
  input  wire logic signed [RAW_W-1:0]      value_in,
  input  wire range_cfg_t                   rng,
  output scl_stat_t                         stat,
  output logic signed [VALUE_BITS-1:0]      result
);

  localparam int QW = VALUE_BITS - 1;
  localparam int W  = VALUE_BITS + 36;
  localparam int CW = $clog2(QW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEN  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_NUM  = 4'd3;
  localparam logic [3:0] S_CHI  = 4'd4;
  localparam logic [3:0] S_CLO  = 4'd5;
  localparam logic [3:0] S_MAG  = 4'd6;
  localparam logic [3:0] S_DZ1  = 4'd7;
  localparam logic [3:0] S_DZ2  = 4'd8;
  localparam logic [3:0] S_DZ3  = 4'd9;
  localparam logic [3:0] S_DZ4  = 4'd10;
  localparam logic [3:0] S_MUL1 = 4'd11;
  localparam logic [3:0] S_MUL2 = 4'd12;
  localparam logic [3:0] S_DIV  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]              st_r, st_nxt;
  logic signed [RAW_W-1:0] v_r, v_nxt;
  logic                    trig_r, trig_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [W-1:0]     den_r, den_nxt;
  logic signed [W-1:0]     num_r, num_nxt;
  logic signed [W-1:0]     t_r, t_nxt;
  logic signed [W-1:0]     mag_r, mag_nxt;
  logic signed [W-1:0]     dsh_r, dsh_nxt;
  logic [QW-1:0]           q_r, q_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;

  logic signed [W-1:0]     alu_a, alu_b, alu_y;
  logic                    alu_sub, alu_neg, alu_zero;

  logic signed [RAW_W-1:0] lo_raw, hi_raw;
  logic signed [W-1:0]     lo_x, hi_x, v2_x, mul_in;
  logic signed [VALUE_BITS-1:0] q_ext;

  gen_alu #(.W(W)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .y      (alu_y),
    .y_neg  (alu_neg),
    .y_zero (alu_zero)
  );

  assign lo_raw = trig_r ? rng.trigger_min : rng.stick_min;
  assign hi_raw = trig_r ? rng.trigger_max : rng.stick_max;
  assign lo_x   = {{(W-RAW_W){lo_raw[RAW_W-1]}}, lo_raw};
  assign hi_x   = {{(W-RAW_W){hi_raw[RAW_W-1]}}, hi_raw};
  assign v2_x   = {{(W-RAW_W-1){v_r[RAW_W-1]}}, v_r, 1'b0};
  // Triggers scale num+den, sticks scale twice the magnitude.
  assign mul_in = trig_r ? t_r : (mag_r <<< 1);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (st_r)
      S_DEN: begin
        alu_a = hi_x;
        alu_b = lo_x;
      end
      S_SUM: begin
        alu_a   = hi_x;
        alu_b   = lo_x;
        alu_sub = 1'b0;
      end
      S_NUM: begin
        alu_a = v2_x;
        alu_b = t_r;
      end
      S_CHI: begin
        alu_a = num_r;
        alu_b = den_r;
      end
      S_CLO: begin
        alu_a   = num_r;
        alu_b   = den_r;
        alu_sub = 1'b0;
      end
      S_MAG: begin
        alu_b = num_r;
      end
      S_DZ1: begin
        alu_a = mag_r <<< 10;
        alu_b = mag_r <<< 4;
      end
      S_DZ2: begin
        alu_a = num_r;
        alu_b = mag_r <<< 3;
      end
      S_DZ3: begin
        alu_a = num_r;
        alu_b = den_r <<< 3;
      end
      S_DZ4: begin
        alu_a = num_r;
        alu_b = den_r;
      end
      S_MUL1: begin
        alu_a = mul_in <<< QW;
        alu_b = mul_in;
      end
      S_MUL2: begin
        alu_a   = num_r;
        alu_b   = den_r;
        alu_sub = 1'b0;
      end
      S_DIV: begin
        alu_a = num_r;
        alu_b = dsh_r;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    v_nxt    = v_r;
    trig_nxt = trig_r;
    idx_nxt  = idx_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    t_nxt    = t_r;
    mag_nxt  = mag_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    unique case (st_r)
      S_IDLE: begin
        if (cmd.go) begin
          v_nxt    = value_in;
          trig_nxt = cmd.trig;
          idx_nxt  = cmd.idx;
          st_nxt   = S_DEN;
        end
      end
      S_DEN: begin
        den_nxt = alu_y;
        st_nxt  = S_SUM;
      end
      S_SUM: begin
        t_nxt = alu_y;
        // An empty or inverted range gives zero without further work.
        if (den_r[W-1] || (den_r == '0)) begin
          q_nxt   = '0;
          neg_nxt = 1'b0;
          st_nxt  = S_DONE;
        end else begin
          st_nxt = S_NUM;
        end
      end
      S_NUM: begin
        num_nxt = alu_y;
        st_nxt  = S_CHI;
      end
      S_CHI: begin
        if (!alu_neg) begin
          num_nxt = den_r;
        end
        st_nxt = S_CLO;
      end
      S_CLO: begin
        // t_r now holds num+den, forced to zero when the low end clamps.
        t_nxt   = (alu_neg || alu_zero) ? '0 : alu_y;
        neg_nxt = num_r[W-1];
        st_nxt  = S_MAG;
      end
      S_MAG: begin
        if (neg_r) begin
          mag_nxt = (t_r == '0) ? den_r : alu_y;
        end else begin
          mag_nxt = num_r;
        end
        st_nxt = S_DZ1;
      end
      S_DZ1: begin
        num_nxt = alu_y;
        st_nxt  = S_DZ2;
      end
      S_DZ2: begin
        num_nxt = alu_y;
        st_nxt  = S_DZ3;
      end
      S_DZ3: begin
        num_nxt = alu_y;
        st_nxt  = S_DZ4;
      end
      S_DZ4: begin
        // Inside the dead zone the value behaves as a centred reading.
        if (alu_neg) begin
          mag_nxt = '0;
          t_nxt   = den_r;
        end
        st_nxt = S_MUL1;
      end
      S_MUL1: begin
        num_nxt = alu_y;
        st_nxt  = S_MUL2;
      end
      S_MUL2: begin
        num_nxt = alu_y;
        dsh_nxt = den_r <<< QW;
        q_nxt   = '0;
        cnt_nxt = CW'(QW - 1);
        st_nxt  = S_DIV;
      end
      S_DIV: begin
        if (!alu_neg) begin
          num_nxt = alu_y;
        end
        q_nxt   = {q_r[QW-2:0], ~alu_neg};
        dsh_nxt = dsh_r >>> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    trig_r <= trig_nxt;
    idx_r  <= idx_nxt;
    neg_r  <= neg_nxt;
    den_r  <= den_nxt;
    num_r  <= num_nxt;
    t_r    <= t_nxt;
    mag_r  <= mag_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign q_ext  = {1'b0, q_r};
  assign result = (!trig_r && neg_r) ? -q_ext : q_ext;

  assign stat.busy = (st_r != S_IDLE);
  assign stat.done = (st_r == S_DONE);
  assign stat.trig = trig_r;
  assign stat.idx  = idx_r;

endmodule
`default_nettype wire
